@@ sv/bmpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpq_pkg
// Shared types and constants for the bucket min priority queue: field widths,
// request codes, link encoding and the channel payload structs.
// ----------------------------------------------------------------------------
package bmpq_pkg;

  localparam int NUM_ENTRIES = 1024;
  localparam int ID_W        = 10;
  localparam int LINK_W      = 11;
  localparam int SCORE_W     = 32;
  localparam int BKT_W       = 16;
  localparam int NUM_BUCKETS = 65536;
  localparam int WORD_BITS   = 64;
  localparam int NUM_WORDS   = NUM_BUCKETS / WORD_BITS;
  localparam int BIT_W       = 6;
  localparam int WIDX_W      = BKT_W - BIT_W;
  localparam int CNT_W       = 11;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_ENTRIES);

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_UPDATE = 2'd2;
  localparam logic [1:0] REQ_LOWEST = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [ID_W-1:0]    entry_id;
    logic [SCORE_W-1:0] score;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  result_id;
    logic             error;
    logic [CNT_W-1:0] entry_count;
  } out_item_t;

  // one entry record: presence, score and both list links
  typedef struct packed {
    logic               present;
    logic [SCORE_W-1:0] score;
    logic [LINK_W-1:0]  fwd;
    logic [LINK_W-1:0]  bwd;
  } entry_t;

endpackage

@@ sv/bucket_min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// bucket_min_priority_queue
// Bucket queue of entry ids kept in three memories with registered reads: entry
// records, bucket heads and occupancy words, driven by one sequencer.
// ----------------------------------------------------------------------------
// Sequencing: a delete of an absent id ends after the entry record read; add,
//   update and delete unlink the old record and scan occupancy words upward
//   (up to 1023) when the lowest bucket empties. Get lowest walks the lowest bucket list.
// Requests: one at a time; in_stall is high until the result is loaded.
// Reset: a clearing pass sweeps the memories; no transfer is
//   accepted until it ends.
module bucket_min_priority_queue import bmpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD_ID, S_CHK, S_U_P, S_U_PW, S_U_N, S_U_NW, S_U_E,
    S_U_OW, S_SCAN, S_U_END, S_L_RD, S_L_WR, S_L_HW, S_G0, S_G1, S_G2, S_FIN
  } state_t;

  state_t              state_r;
  logic [BKT_W-1:0]    clr_r;
  logic [1:0]          req_r;
  logic [ID_W-1:0]     id_r;
  logic [SCORE_W-1:0]  score_r;
  logic [ID_W-1:0]     rid_r;
  logic                err_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [BKT_W-1:0]    low_bkt_r;
  logic                low_vld_r;
  logic [LINK_W-1:0]   p_r;
  logic [LINK_W-1:0]   n_r;
  logic [BKT_W-1:0]    ob_r;
  logic [WIDX_W-1:0]   scan_w_r;
  logic [ID_W-1:0]     hlink_r;
  logic [ID_W-1:0]     target_r;
  logic [SCORE_W-1:0]  tscore_r;
  logic                first_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  // memories
  entry_t              ent_mem [NUM_ENTRIES];
  logic [LINK_W-1:0]   head_mem [NUM_BUCKETS];
  logic [WORD_BITS-1:0] occ_mem [NUM_WORDS];

  logic                ent_we;
  logic [ID_W-1:0]     ent_waddr, ent_raddr;
  entry_t              ent_wdata, ent_rdata;
  logic                head_we;
  logic [BKT_W-1:0]    head_waddr, head_raddr;
  logic [LINK_W-1:0]   head_wdata, head_rdata;
  logic                occ_we;
  logic [WIDX_W-1:0]   occ_waddr, occ_raddr;
  logic [WORD_BITS-1:0] occ_wdata, occ_rdata;

  logic [BKT_W-1:0]    bkt_new;
  logic [WORD_BITS-1:0] occ_cleared, occ_masked, ffs_in;
  logic                ffs_found;
  logic [BIT_W-1:0]    ffs_idx;

  assign bkt_new     = score_r[SCORE_W-1 -: BKT_W];
  assign occ_cleared = occ_rdata & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << ob_r[BIT_W-1:0]);
  assign occ_masked  = occ_cleared & ({WORD_BITS{1'b1}} << ob_r[BIT_W-1:0]);
  assign ffs_in      = (state_r == S_U_OW) ? occ_masked : occ_rdata;

  bmpq_ffs64 u_ffs (
    .word_in (ffs_in),
    .found   (ffs_found),
    .bit_idx (ffs_idx)
  );

  // entry memory
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata <= ent_mem[ent_raddr];
  end

  // bucket head memory
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rdata <= head_mem[head_raddr];
  end

  // occupancy memory
  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    occ_rdata <= occ_mem[occ_raddr];
  end

  // memory port control per sequencer state
  always_comb begin
    ent_we     = 1'b0;
    ent_waddr  = id_r;
    ent_wdata  = ent_rdata;
    ent_raddr  = id_r;
    head_we    = 1'b0;
    head_waddr = ob_r;
    head_wdata = NULL_LINK;
    head_raddr = bkt_new;
    occ_we     = 1'b0;
    occ_waddr  = ob_r[BKT_W-1 -: WIDX_W];
    occ_wdata  = occ_rdata;
    occ_raddr  = ob_r[BKT_W-1 -: WIDX_W];
    unique case (state_r)
      S_CLR: begin
        ent_we     = 1'b1;
        ent_waddr  = clr_r[ID_W-1:0];
        ent_wdata  = '0;
        head_we    = 1'b1;
        head_waddr = clr_r;
        head_wdata = NULL_LINK;
        occ_we     = 1'b1;
        occ_waddr  = clr_r[WIDX_W-1:0];
        occ_wdata  = '0;
      end
      S_U_P: begin
        if (p_r[LINK_W-1]) begin
          head_we    = 1'b1;
          head_waddr = ob_r;
          head_wdata = n_r;
        end else begin
          ent_raddr = p_r[ID_W-1:0];
        end
      end
      S_U_PW: begin
        ent_we        = 1'b1;
        ent_waddr     = p_r[ID_W-1:0];
        ent_wdata.fwd = n_r;
      end
      S_U_N: begin
        ent_raddr = n_r[ID_W-1:0];
      end
      S_U_NW: begin
        ent_we        = 1'b1;
        ent_waddr     = n_r[ID_W-1:0];
        ent_wdata.bwd = p_r;
      end
      S_U_E: begin
        ent_we    = 1'b1;
        ent_waddr = id_r;
        ent_wdata = '0;
      end
      S_U_OW: begin
        occ_we    = 1'b1;
        occ_wdata = occ_cleared;
        occ_raddr = ob_r[BKT_W-1 -: WIDX_W] + 1'b1;
      end
      S_SCAN: begin
        occ_raddr = scan_w_r + 1'b1;
      end
      S_L_RD: begin
        head_raddr = bkt_new;
        occ_raddr  = bkt_new[BKT_W-1 -: WIDX_W];
      end
      S_L_WR: begin
        ent_we     = 1'b1;
        ent_waddr  = id_r;
        ent_wdata  = '{present: 1'b1, score: score_r, fwd: head_rdata, bwd: NULL_LINK};
        head_we    = 1'b1;
        head_waddr = bkt_new;
        head_wdata = {1'b0, id_r};
        occ_we     = 1'b1;
        occ_waddr  = bkt_new[BKT_W-1 -: WIDX_W];
        occ_wdata  = occ_rdata | ({{(WORD_BITS-1){1'b0}}, 1'b1} << bkt_new[BIT_W-1:0]);
        ent_raddr  = head_rdata[ID_W-1:0];
      end
      S_L_HW: begin
        ent_we        = 1'b1;
        ent_waddr     = hlink_r;
        ent_wdata.bwd = {1'b0, id_r};
      end
      S_G0: begin
        head_raddr = low_bkt_r;
      end
      S_G1: begin
        ent_raddr = head_rdata[ID_W-1:0];
      end
      S_G2: begin
        ent_raddr = ent_rdata.fwd[ID_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      low_bkt_r   <= '0;
      low_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result leaves unless a new one is loaded below
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data.req_type;
            id_r    <= in_data.entry_id;
            score_r <= in_data.score;
            rid_r   <= in_data.entry_id;
            err_r   <= 1'b0;
            state_r <= (in_data.req_type == REQ_LOWEST) ? S_G0 : S_RD_ID;
          end
        end
        S_RD_ID: state_r <= S_CHK;
        S_CHK: begin
          p_r  <= ent_rdata.bwd;
          n_r  <= ent_rdata.fwd;
          ob_r <= ent_rdata.score[SCORE_W-1 -: BKT_W];
          if (ent_rdata.present) begin
            state_r <= S_U_P;
          end else if (req_r == REQ_DELETE) begin
            err_r   <= 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_L_RD;
          end
        end
        S_U_P:  state_r <= p_r[LINK_W-1] ? S_U_N : S_U_PW;
        S_U_PW: state_r <= S_U_N;
        S_U_N:  state_r <= n_r[LINK_W-1] ? S_U_E : S_U_NW;
        S_U_NW: state_r <= S_U_E;
        S_U_E: begin
          cnt_r   <= cnt_r - 1'b1;
          state_r <= (p_r[LINK_W-1] && n_r[LINK_W-1]) ? S_U_OW : S_U_END;
        end
        S_U_OW: begin
          state_r <= S_U_END;
          if (low_vld_r && ob_r == low_bkt_r) begin
            // rescan upward from the bucket just emptied
            if (ffs_found) begin
              low_bkt_r <= {ob_r[BKT_W-1 -: WIDX_W], ffs_idx};
            end else if (&ob_r[BKT_W-1 -: WIDX_W]) begin
              low_vld_r <= 1'b0;
              low_bkt_r <= '0;
            end else begin
              scan_w_r <= ob_r[BKT_W-1 -: WIDX_W] + 1'b1;
              state_r  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (ffs_found) begin
            low_bkt_r <= {scan_w_r, ffs_idx};
            state_r   <= S_U_END;
          end else if (&scan_w_r) begin
            low_vld_r <= 1'b0;
            low_bkt_r <= '0;
            state_r   <= S_U_END;
          end else begin
            scan_w_r <= scan_w_r + 1'b1;
          end
        end
        S_U_END: begin
          if (cnt_r == '0) begin
            low_vld_r <= 1'b0;
          end
          state_r <= (req_r == REQ_DELETE) ? S_FIN : S_L_RD;
        end
        S_L_RD: state_r <= S_L_WR;
        S_L_WR: begin
          cnt_r   <= cnt_r + 1'b1;
          hlink_r <= head_rdata[ID_W-1:0];
          if (!low_vld_r || bkt_new < low_bkt_r) begin
            low_bkt_r <= bkt_new;
            low_vld_r <= 1'b1;
          end
          state_r <= head_rdata[LINK_W-1] ? S_FIN : S_L_HW;
        end
        S_L_HW: state_r <= S_FIN;
        S_G0: begin
          if (cnt_r == '0 || !low_vld_r) begin
            err_r   <= 1'b1;
            rid_r   <= '0;
            state_r <= S_FIN;
          end else begin
            state_r <= S_G1;
          end
        end
        S_G1: begin
          if (head_rdata[LINK_W-1]) begin
            err_r   <= 1'b1;
            rid_r   <= '0;
            state_r <= S_FIN;
          end else begin
            target_r <= head_rdata[ID_W-1:0];
            hlink_r  <= head_rdata[ID_W-1:0];
            first_r  <= 1'b1;
            state_r  <= S_G2;
          end
        end
        S_G2: begin
          // walk the list, later entries win ties
          first_r <= 1'b0;
          if (first_r || ent_rdata.score <= tscore_r) begin
            target_r <= hlink_r;
            tscore_r <= ent_rdata.score;
          end
          hlink_r <= ent_rdata.fwd[ID_W-1:0];
          if (ent_rdata.fwd[LINK_W-1]) begin
            rid_r   <= (first_r || ent_rdata.score <= tscore_r) ? hlink_r : target_r;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{result_id: rid_r, error: err_r, entry_count: cnt_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/bmpq_ffs64.sv @@
// ----------------------------------------------------------------------------
// bmpq_ffs64
// Finds the lowest set bit of one 64-bit occupancy word.
// ----------------------------------------------------------------------------
module bmpq_ffs64 import bmpq_pkg::*; (
  input  logic [WORD_BITS-1:0] word_in,
  output logic                 found,
  output logic [BIT_W-1:0]     bit_idx
);

  // priority encode, lowest index wins
  always_comb begin
    bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word_in[i]) begin
        bit_idx = BIT_W'(i);
      end
    end
  end

  assign found = |word_in;

endmodule

@@ bench/tb_bucket_min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// tb_bucket_min_priority_queue
// Self-checking bench for the bucket min priority queue: directed requests
// cover the error and reuse cases, then random add/delete/update/lowest
// traffic over a small id and bucket set runs through several idle and stall
// phases. A scoreboard predicts each response and compares it on transfer.
// ----------------------------------------------------------------------------
module tb_bucket_min_priority_queue import bmpq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  class queue_scoreboard;
    logic [SCORE_W-1:0] score_of [NUM_ENTRIES];
    bit                 held     [NUM_ENTRIES];
    // bucket lists, head first
    int                 chain    [int][$];
    int                 n_held;
    out_item_t          pending  [$];
    int                 n_fail;
    int                 n_lowest;
    int                 n_err;

    function new();
      n_held = 0;
      n_fail = 0;
      n_lowest = 0;
      n_err = 0;
      foreach (held[i]) held[i] = 0;
    endfunction

    function int bucket_idx(logic [SCORE_W-1:0] s);
      return int'(s >> 16);
    endfunction

    function void unlink(int id);
      int b;
      int pos [$];
      b = bucket_idx(score_of[id]);
      pos = chain[b].find_first_index(x) with (x == id);
      chain[b].delete(pos[0]);
      if (chain[b].size() == 0) chain.delete(b);
      held[id] = 0;
      n_held--;
    endfunction

    // note an accepted request and queue its expected response
    function void note_request(in_item_t r);
      out_item_t e;
      int id;
      int b;
      int best;
      id = int'(r.entry_id);
      e.result_id = r.entry_id;
      e.error = 1'b0;
      if (r.req_type == REQ_LOWEST) begin
        n_lowest++;
        if (n_held == 0) begin
          e.error = 1'b1;
          e.result_id = '0;
        end else begin
          void'(chain.first(b));
          best = chain[b][0];
          // later entries in the list win ties
          for (int k = 1; k < chain[b].size(); k++)
            if (score_of[chain[b][k]] <= score_of[best]) best = chain[b][k];
          e.result_id = ID_W'(best);
        end
      end else if (r.req_type == REQ_DELETE) begin
        if (held[id]) unlink(id);
        else e.error = 1'b1;
      end else begin
        if (held[id]) unlink(id);
        score_of[id] = r.score;
        b = bucket_idx(r.score);
        chain[b].push_front(id);
        held[id] = 1;
        n_held++;
      end
      e.entry_count = CNT_W'(n_held);
      if (e.error) n_err++;
      pending.push_back(e);
    endfunction

    // compare one response with the oldest expectation
    function void check_response(out_item_t a);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected response id=%0d", a.result_id);
        n_fail++;
        return;
      end
      e = pending.pop_front();
      if (a.result_id !== e.result_id) begin
        $error("result_id: expected %0d, actual %0d", e.result_id, a.result_id);
        n_fail++;
      end
      if (a.error !== e.error) begin
        $error("error: expected %0d, actual %0d", e.error, a.error);
        n_fail++;
      end
      if (a.entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", e.entry_count, a.entry_count);
        n_fail++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  queue_scoreboard sb;

  bucket_min_priority_queue DUT (.*);

  always #1 clk = ~clk;

  // receiver side: random stall, check on transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_response(out_data);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // present one request and hold it until transfer
  task automatic send_req(logic [1:0] rt, int id, logic [SCORE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: rt, entry_id: ID_W'(id), score: s};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(in_data);
  endtask

  // random score: mostly few buckets for ties and chains, sometimes extremes
  function automatic logic [SCORE_W-1:0] rand_score();
    case ($urandom_range(9))
      0: return $urandom();
      1: return {16'hFFFF, 16'($urandom())};
      2: return {16'($urandom_range(200)), 16'($urandom_range(3))};
      default: return {16'($urandom_range(130)), 16'($urandom())};
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    int r;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) send_req(REQ_ADD, $urandom_range(47), rand_score());
      else if (r < 60) send_req(REQ_DELETE, $urandom_range(47), rand_score());
      else if (r < 75) send_req(REQ_UPDATE, $urandom_range(47), rand_score());
      else if (r < 95) send_req(REQ_LOWEST, $urandom_range(1023), $urandom());
      else send_req(2'($urandom()), $urandom_range(1023), $urandom());
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed: empty queue, absent delete, reuse, ties, extremes
    send_req(REQ_LOWEST, 5, 32'd0);
    send_req(REQ_DELETE, 1023, 32'hFFFF_FFFF);
    send_req(REQ_ADD, 0, 32'd0);
    send_req(REQ_ADD, 1023, 32'hFFFF_FFFF);
    send_req(REQ_LOWEST, 0, 32'd0);
    send_req(REQ_ADD, 0, 32'h0001_0005);
    send_req(REQ_ADD, 7, 32'h0001_0005);
    send_req(REQ_ADD, 8, 32'h0001_0009);
    send_req(REQ_LOWEST, 0, 32'd0);
    send_req(REQ_UPDATE, 9, 32'h0000_FFFF);
    send_req(REQ_LOWEST, 0, 32'd0);
    send_req(REQ_UPDATE, 9, 32'h0040_0000);
    send_req(REQ_LOWEST, 0, 32'd0);
    send_req(REQ_DELETE, 0, 32'd0);
    send_req(REQ_DELETE, 0, 32'd0);
    send_req(REQ_DELETE, 7, 32'd0);
    send_req(REQ_DELETE, 8, 32'd0);
    send_req(REQ_LOWEST, 0, 32'd0);
    send_req(REQ_DELETE, 9, 32'd0);
    send_req(REQ_DELETE, 1023, 32'd0);
    send_req(REQ_LOWEST, 0, 32'd0);
    send_req(REQ_UPDATE, 512, 32'h5555_AAAA);
    send_req(REQ_DELETE, 512, 32'd0);
    // random traffic through the idle and stall phases
    random_phase(190, 0, 0);
    random_phase(190, 54, 0);
    random_phase(190, 0, 54);
    random_phase(190, 31, 31);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d lowest-score queries and %0d error responses",
             sb.n_lowest, sb.n_err);
    if (sb.n_fail == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // timeout: clearing pass plus slow worst-case scans
  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule

@@ sim.f @@
sv/bmpq_pkg.sv
sv/bmpq_ffs64.sv
sv/bucket_min_priority_queue.sv
bench/tb_bucket_min_priority_queue.sv
